// File: design/bps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bucketed priority stack package
// Shared constants, codes, state encoding and controller/datapath interface.
// ----------------------------------------------------------------------------
package bps_pkg;

   localparam int DEF_LEVELS      = 16;
   localparam int DEF_CAPACITY    = 256;
   localparam int DEF_ELEM_WIDTH  = 32;

   localparam int ELEMENT_W       = 32;
   localparam int LEVEL_W         = 4;
   localparam int COUNT_OUT_W     = 9;
   localparam int FIELD_LEVELS    = 2 ** LEVEL_W;
   localparam logic [LEVEL_W-1:0] HIGHEST_LEVEL_RESET = 4'd15;

   localparam logic KIND_PUSH = 1'b0;
   localparam logic KIND_POP  = 1'b1;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_LEVEL = 2'd1,
      ST_FULL  = 2'd2,
      ST_EMPTY = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_LINK,
      S_UPDATE,
      S_TOP,
      S_REPLY
   } state_type;

   typedef struct packed {
      logic capture;
      logic link_read;
      logic commit;
      logic top_read;
   } ctl_cmd_type;

   typedef struct packed {
      logic fault;
   } ctl_status_type;

endpackage

// File: design/bps_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bucketed priority stack controller
// Sequences transactions: link read, update unless faulted, top read, reply.
// ----------------------------------------------------------------------------
module bps_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   output logic                    rsp_strobe,
   output bps_pkg::ctl_cmd_type    cmd,
   input  bps_pkg::ctl_status_type sts
);
   import bps_pkg::*;

   state_type state_ff;
   state_type state_in;
   logic      ready;

   assign ready = (state_ff == S_IDLE) || (state_ff == S_REPLY);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) state_in = S_LINK;
         end
         S_LINK: begin
            state_in = sts.fault ? S_TOP : S_UPDATE;
         end
         S_UPDATE: begin
            state_in = S_TOP;
         end
         S_TOP: begin
            state_in = S_REPLY;
         end
         S_REPLY: begin
            state_in = start ? S_LINK : S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd         = '0;
      cmd.capture = start && ready;
      busy        = !ready;
      rsp_strobe  = 1'b0;
      unique case (state_ff)
         S_IDLE:   ;
         S_LINK:   cmd.link_read = 1'b1;
         S_UPDATE: cmd.commit    = 1'b1;
         S_TOP:    cmd.top_read  = 1'b1;
         S_REPLY:  rsp_strobe    = 1'b1;
         default:  ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: design/bps_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bucketed priority stack datapath
// Level heads, node memories, free list, counters and the result registers.
// ----------------------------------------------------------------------------
module bps_datapath #(
   parameter int LEVELS     = bps_pkg::DEF_LEVELS,
   parameter int CAPACITY   = bps_pkg::DEF_CAPACITY,
   parameter int ELEM_WIDTH = bps_pkg::DEF_ELEM_WIDTH
) (
   input  logic                                clock,
   input  logic                                reset,
   input  bps_pkg::ctl_cmd_type                cmd,
   output bps_pkg::ctl_status_type             sts,
   input  logic                                req_kind,
   input  logic [bps_pkg::ELEMENT_W-1:0]       req_element,
   input  logic [bps_pkg::LEVEL_W-1:0]         req_level,
   input  logic                                csr_write_enable,
   input  logic [bps_pkg::LEVEL_W-1:0]         csr_write_data,
   output logic [1:0]                          rsp_status,
   output logic [bps_pkg::ELEMENT_W-1:0]       rsp_top_element,
   output logic [bps_pkg::LEVEL_W-1:0]         rsp_top_level,
   output logic [bps_pkg::COUNT_OUT_W-1:0]     rsp_count,
   output logic                                rsp_is_empty
);
   import bps_pkg::*;

   localparam int USED_LEVELS = (LEVELS < FIELD_LEVELS) ? LEVELS : FIELD_LEVELS;
   localparam int LVL_W       = $clog2(USED_LEVELS);
   localparam int NODE_W      = $clog2(CAPACITY);
   localparam int COUNT_W     = $clog2(CAPACITY + 1);
   localparam int LINK_W      = NODE_W + 1;

   logic                   kind_ff;
   logic [ELEM_WIDTH-1:0]  elem_ff;
   logic [LEVEL_W-1:0]     level_ff;
   logic [LEVEL_W-1:0]     highest_level_ff;

   logic [NODE_W-1:0]      level_head_ff [USED_LEVELS];
   logic [USED_LEVELS-1:0] nonempty_ff;
   logic [NODE_W-1:0]      free_head_ff;
   logic                   free_valid_ff;
   logic [COUNT_W-1:0]     fresh_ff;
   logic [COUNT_W-1:0]     count_ff;

   logic [NODE_W-1:0]      node_ff;
   logic [LVL_W-1:0]       lvl_ff;
   logic                   use_free_ff;
   status_type             status_ff;
   logic [LINK_W-1:0]      link_rd_ff;
   logic [ELEM_WIDTH-1:0]  value_rd_ff;
   logic [LVL_W-1:0]       top_level_ff;
   logic                   empty_ff;

   logic [LINK_W-1:0]      link_mem  [CAPACITY];
   logic [ELEM_WIDTH-1:0]  value_mem [CAPACITY];

   logic [LVL_W-1:0]       enc_idx;
   logic [LVL_W-1:0]       head_sel;
   logic [NODE_W-1:0]      head_rd;
   logic [NODE_W-1:0]      link_addr;
   logic [NODE_W-1:0]      node_pick;
   status_type             status_in;
   logic                   level_bad;
   logic                   store_full;
   logic [LINK_W-1:0]      link_wdata;
   logic                   push_commit;
   logic                   pop_commit;

   always_comb begin
      enc_idx = '0;
      for (int i = 0; i < USED_LEVELS; i++) begin
         if (nonempty_ff[i]) enc_idx = LVL_W'(i);
      end
   end

   assign head_sel    = cmd.commit ? lvl_ff : enc_idx;
   assign head_rd     = level_head_ff[head_sel];
   assign push_commit = cmd.commit && (kind_ff == KIND_PUSH);
   assign pop_commit  = cmd.commit && (kind_ff == KIND_POP);

   assign level_bad  = (level_ff > highest_level_ff) || (32'(level_ff) >= LEVELS);
   assign store_full = !free_valid_ff && (fresh_ff == COUNT_W'(CAPACITY));

   always_comb begin
      status_in = ST_OK;
      if (kind_ff == KIND_PUSH) begin
         if (level_bad) begin
            status_in = ST_LEVEL;
         end else if (store_full) begin
            status_in = ST_FULL;
         end
      end else if (nonempty_ff == '0) begin
         status_in = ST_EMPTY;
      end
   end

   assign sts.fault = (status_in != ST_OK);

   assign link_addr = (kind_ff == KIND_POP) ? head_rd : free_head_ff;
   assign node_pick = (kind_ff == KIND_POP) ? head_rd :
                      (free_valid_ff ? free_head_ff : fresh_ff[NODE_W-1:0]);
   assign link_wdata = (kind_ff == KIND_POP) ? {free_valid_ff, free_head_ff}
                                             : {nonempty_ff[lvl_ff], head_rd};

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff  <= req_kind;
         elem_ff  <= ELEM_WIDTH'(req_element);
         level_ff <= req_level;
      end
      if (cmd.link_read) begin
         node_ff     <= node_pick;
         lvl_ff      <= (kind_ff == KIND_POP) ? enc_idx : level_ff[LVL_W-1:0];
         use_free_ff <= free_valid_ff;
      end
      if (cmd.top_read) begin
         top_level_ff <= enc_idx;
         empty_ff     <= (nonempty_ff == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         status_ff <= ST_OK;
      end else if (cmd.link_read) begin
         status_ff <= status_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit || pop_commit) begin
         level_head_ff[lvl_ff] <= push_commit ? node_ff : link_rd_ff[NODE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         highest_level_ff <= HIGHEST_LEVEL_RESET;
         nonempty_ff      <= '0;
         free_head_ff     <= '0;
         free_valid_ff    <= 1'b0;
         fresh_ff         <= '0;
         count_ff         <= '0;
      end else begin
         if (csr_write_enable) highest_level_ff <= csr_write_data;
         if (push_commit) begin
            nonempty_ff[lvl_ff] <= 1'b1;
            count_ff            <= count_ff + 1'b1;
            if (use_free_ff) begin
               free_head_ff  <= link_rd_ff[NODE_W-1:0];
               free_valid_ff <= link_rd_ff[NODE_W];
            end else begin
               fresh_ff <= fresh_ff + 1'b1;
            end
         end else if (pop_commit) begin
            nonempty_ff[lvl_ff] <= link_rd_ff[NODE_W];
            free_head_ff        <= node_ff;
            free_valid_ff       <= 1'b1;
            if (count_ff != '0) count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) link_mem[node_ff] <= link_wdata;
      if (cmd.link_read) link_rd_ff <= link_mem[link_addr];
   end

   always_ff @(posedge clock) begin
      if (push_commit) value_mem[node_ff] <= elem_ff;
      if (cmd.top_read) value_rd_ff <= value_mem[head_rd];
   end

   assign rsp_status      = status_ff;
   assign rsp_top_element = empty_ff ? '0 : ELEMENT_W'(value_rd_ff);
   assign rsp_top_level   = empty_ff ? '0 : LEVEL_W'(top_level_ff);
   assign rsp_count       = COUNT_OUT_W'(count_ff);
   assign rsp_is_empty    = empty_ff;

   a_count_matches_levels: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) == (nonempty_ff == '0))
      else $error("Element count disagrees with the level occupancy.");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(CAPACITY))
      else $error("Element count exceeds the capacity.");

   a_free_list_accounting: assert property (@(posedge clock) disable iff (reset)
      !free_valid_ff |-> (count_ff == fresh_ff))
      else $error("Nodes are lost while the free list is empty.");

   a_commit_only_ok: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> (status_ff == ST_OK))
      else $error("State was updated by a faulted transaction.");

endmodule

// File: design/bucketed_priority_stack_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bucketed priority stack
// A transaction is accepted on a clock edge with start high and busy low. It
// passes through link read, update, top read and reply, and its result comes
// with rsp_strobe in the reply state; a faulted transaction skips the update.
// The node link memory and then the node value memory are each read through
// a registered port one after the other. busy is low during the reply cycle,
// so a new transaction may be accepted there, but not earlier. The result is
// shown for that single cycle only and the receiver cannot hold it off. The
// highest level register is written at any edge with csr_write_enable high;
// the user must write it only while idle: the block does not enforce this.
// ----------------------------------------------------------------------------
module bucketed_priority_stack_top #(
   parameter int LEVELS     = bps_pkg::DEF_LEVELS,
   parameter int CAPACITY   = bps_pkg::DEF_CAPACITY,
   parameter int ELEM_WIDTH = bps_pkg::DEF_ELEM_WIDTH
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic                            req_kind,
   input  logic [bps_pkg::ELEMENT_W-1:0]   req_element,
   input  logic [bps_pkg::LEVEL_W-1:0]     req_level,
   input  logic                            csr_write_enable,
   input  logic [bps_pkg::LEVEL_W-1:0]     csr_write_data,
   output logic                            rsp_strobe,
   output logic [1:0]                      rsp_status,
   output logic [bps_pkg::ELEMENT_W-1:0]   rsp_top_element,
   output logic [bps_pkg::LEVEL_W-1:0]     rsp_top_level,
   output logic [bps_pkg::COUNT_OUT_W-1:0] rsp_count,
   output logic                            rsp_is_empty
);
   import bps_pkg::*;

   ctl_cmd_type    cmd;
   ctl_status_type sts;

   bps_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .cmd        (cmd),
      .sts        (sts)
   );

   bps_datapath #(
      .LEVELS     (LEVELS),
      .CAPACITY   (CAPACITY),
      .ELEM_WIDTH (ELEM_WIDTH)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_kind         (req_kind),
      .req_element      (req_element),
      .req_level        (req_level),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .rsp_status       (rsp_status),
      .rsp_top_element  (rsp_top_element),
      .rsp_top_level    (rsp_top_level),
      .rsp_count        (rsp_count),
      .rsp_is_empty     (rsp_is_empty)
   );

endmodule

// File: tb/bucketed_priority_stack_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bucketed priority stack testbench
// Drives push and pop transactions through the start/busy handshake and
// checks every reply against the table or a behavioral copy of the per-level
// stacks, node free list and highest level register. A short table covers the
// corner cases, then random traffic fills the store to full, drains it past
// empty and mixes both under several register settings and idle patterns.
// ----------------------------------------------------------------------------
module bucketed_priority_stack_top_tb;
   import bps_pkg::*;

   localparam int NODE_W = $clog2(DEF_CAPACITY);

   typedef struct packed {
      status_type              status;
      logic [ELEMENT_W-1:0]    top_element;
      logic [LEVEL_W-1:0]      top_level;
      logic [COUNT_OUT_W-1:0]  count;
      logic                    is_empty;
   } stack_result_type;

   typedef struct packed {
      logic                    is_cfg;
      logic                    kind;
      logic [ELEMENT_W-1:0]    element;
      logic [LEVEL_W-1:0]      level;
      logic                    checked;
      stack_result_type        typed_res;
   } stimulus_row_type;

   localparam stack_result_type EMPTY_RESULT = '{ST_EMPTY, 32'h0, 4'd0, 9'd0, 1'b1};
   localparam stack_result_type NO_CHECK     = '{ST_OK, 32'h0, 4'd0, 9'd0, 1'b0};

   logic                    clock;
   logic                    reset;
   logic                    start;
   logic                    busy;
   logic                    req_kind;
   logic [ELEMENT_W-1:0]    req_element;
   logic [LEVEL_W-1:0]      req_level;
   logic                    csr_write_enable;
   logic [LEVEL_W-1:0]      csr_write_data;
   logic                    rsp_strobe;
   logic [1:0]              rsp_status;
   logic [ELEMENT_W-1:0]    rsp_top_element;
   logic [LEVEL_W-1:0]      rsp_top_level;
   logic [COUNT_OUT_W-1:0]  rsp_count;
   logic                    rsp_is_empty;

   // Behavioral copy of the stack store.
   bit [NODE_W-1:0]         lvl_head [DEF_LEVELS];
   bit                      lvl_used [DEF_LEVELS];
   bit [ELEMENT_W-1:0]      node_val [DEF_CAPACITY];
   bit [NODE_W-1:0]         node_next [DEF_CAPACITY];
   bit                      node_next_ok [DEF_CAPACITY];
   bit [NODE_W-1:0]         free_head;
   bit                      free_ok;
   int                      fresh_mark;
   int                      stored;
   logic [LEVEL_W-1:0]      highest_level = HIGHEST_LEVEL_RESET;

   stack_result_type        expected_q [$];
   int                      mismatch_count = 0;
   int                      send_idle_pct = 0;

   stimulus_row_type directed_rows [26] = '{
      '{1'b0, KIND_POP,  32'h0,         4'd0,  1'b1, EMPTY_RESULT},
      '{1'b0, KIND_PUSH, 32'hFFFF_FFFF, 4'd15, 1'b1,
        '{ST_OK, 32'hFFFF_FFFF, 4'd15, 9'd1, 1'b0}},
      '{1'b0, KIND_PUSH, 32'h0,         4'd0,  1'b1,
        '{ST_OK, 32'hFFFF_FFFF, 4'd15, 9'd2, 1'b0}},
      '{1'b0, KIND_PUSH, 32'h8000_0001, 4'd7,  1'b0, NO_CHECK},
      '{1'b0, KIND_PUSH, 32'hA5A5_A5A5, 4'd15, 1'b0, NO_CHECK},
      '{1'b0, KIND_POP,  32'h0,         4'd0,  1'b0, NO_CHECK},
      '{1'b0, KIND_POP,  32'hFFFF_FFFF, 4'd15, 1'b0, NO_CHECK},
      '{1'b0, KIND_POP,  32'h0,         4'd0,  1'b0, NO_CHECK},
      '{1'b0, KIND_POP,  32'h0,         4'd0,  1'b0, NO_CHECK},
      '{1'b0, KIND_POP,  32'h0,         4'd0,  1'b1, EMPTY_RESULT},
      '{1'b1, KIND_PUSH, 32'h0,         4'd0,  1'b0, NO_CHECK},
      '{1'b0, KIND_PUSH, 32'h5,         4'd1,  1'b1,
        '{ST_LEVEL, 32'h0, 4'd0, 9'd0, 1'b1}},
      '{1'b0, KIND_PUSH, 32'h7,         4'd0,  1'b1,
        '{ST_OK, 32'h7, 4'd0, 9'd1, 1'b0}},
      '{1'b0, KIND_PUSH, 32'h9,         4'd15, 1'b1,
        '{ST_LEVEL, 32'h7, 4'd0, 9'd1, 1'b0}},
      '{1'b1, KIND_PUSH, 32'h0,         4'd15, 1'b0, NO_CHECK},
      '{1'b0, KIND_PUSH, 32'h1234_5678, 4'd15, 1'b0, NO_CHECK},
      '{1'b0, KIND_PUSH, 32'h0F0F_0F0F, 4'd9,  1'b0, NO_CHECK},
      '{1'b1, KIND_PUSH, 32'h0,         4'd3,  1'b0, NO_CHECK},
      '{1'b0, KIND_PUSH, 32'h55,        4'd2,  1'b0, NO_CHECK},
      '{1'b0, KIND_PUSH, 32'h66,        4'd4,  1'b0, NO_CHECK},
      '{1'b0, KIND_POP,  32'h0,         4'd0,  1'b0, NO_CHECK},
      '{1'b0, KIND_POP,  32'h0,         4'd0,  1'b0, NO_CHECK},
      '{1'b0, KIND_POP,  32'h0,         4'd0,  1'b0, NO_CHECK},
      '{1'b0, KIND_POP,  32'h0,         4'd0,  1'b0, NO_CHECK},
      '{1'b0, KIND_POP,  32'h0,         4'd0,  1'b1, EMPTY_RESULT},
      '{1'b1, KIND_PUSH, 32'h0,         4'd15, 1'b0, NO_CHECK}
   };

   bucketed_priority_stack_top DUT (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_kind         (req_kind),
      .req_element      (req_element),
      .req_level        (req_level),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .rsp_strobe       (rsp_strobe),
      .rsp_status       (rsp_status),
      .rsp_top_element  (rsp_top_element),
      .rsp_top_level    (rsp_top_level),
      .rsp_count        (rsp_count),
      .rsp_is_empty     (rsp_is_empty)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("bucketed_priority_stack_top: mismatch");
      $finish;
   end

   function automatic int highest_used();
      for (int i = DEF_LEVELS - 1; i >= 0; i--) begin
         if (lvl_used[i]) return i;
      end
      return -1;
   endfunction

   function automatic stack_result_type apply_to_stack(logic kind, logic [ELEMENT_W-1:0] elem,
                                                       logic [LEVEL_W-1:0] lvl);
      stack_result_type r;
      int top;
      bit [NODE_W-1:0] node;
      r.status = ST_OK;
      if (kind == KIND_PUSH) begin
         if (lvl > highest_level) begin
            r.status = ST_LEVEL;
         end else if (!free_ok && fresh_mark >= DEF_CAPACITY) begin
            r.status = ST_FULL;
         end else begin
            if (free_ok) begin
               node = free_head;
               free_head = node_next[node];
               free_ok = node_next_ok[node];
            end else begin
               node = fresh_mark[NODE_W-1:0];
               fresh_mark++;
            end
            node_val[node] = elem;
            node_next[node] = lvl_head[lvl];
            node_next_ok[node] = lvl_used[lvl];
            lvl_head[lvl] = node;
            lvl_used[lvl] = 1'b1;
            stored++;
         end
      end else begin
         top = highest_used();
         if (top < 0) begin
            r.status = ST_EMPTY;
         end else begin
            node = lvl_head[top];
            lvl_head[top] = node_next[node];
            lvl_used[top] = node_next_ok[node];
            node_next[node] = free_head;
            node_next_ok[node] = free_ok;
            free_head = node;
            free_ok = 1'b1;
            stored--;
         end
      end
      top = highest_used();
      r.count = stored[COUNT_OUT_W-1:0];
      r.is_empty = (top < 0);
      if (top < 0) begin
         r.top_element = '0;
         r.top_level = '0;
      end else begin
         r.top_element = node_val[lvl_head[top]];
         r.top_level = top[LEVEL_W-1:0];
      end
      return r;
   endfunction

   function automatic string format_result(stack_result_type r);
      return $sformatf("status %0d top %h level %0d count %0d empty %0d",
                       r.status, r.top_element, r.top_level, r.count, r.is_empty);
   endfunction

   always @(posedge clock) begin
      stack_result_type seen;
      stack_result_type want;
      if (!reset && rsp_strobe) begin
         seen = '{status_type'(rsp_status), rsp_top_element, rsp_top_level, rsp_count,
                  rsp_is_empty};
         if (expected_q.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
               $display("%0t: reply with no transaction pending: %s", $time,
                        format_result(seen));
            end
         end else begin
            want = expected_q.pop_front();
            if (seen !== want) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("%0t: expected %s", $time, format_result(want));
                  $display("%0t: actual   %s", $time, format_result(seen));
               end
            end
         end
      end
   end

   task automatic send_item(logic kind, logic [ELEMENT_W-1:0] elem, logic [LEVEL_W-1:0] lvl,
                            logic checked, stack_result_type typed_res);
      stack_result_type predicted;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_kind <= kind;
      req_element <= elem;
      req_level <= lvl;
      do @(posedge clock); while (busy !== 1'b0);
      predicted = apply_to_stack(kind, elem, lvl);
      expected_q.push_back(checked ? typed_res : predicted);
   endtask

   task automatic write_highest_level(logic [LEVEL_W-1:0] value);
      start <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      highest_level = value;
   endtask

   task automatic run_random(int items, int push_pct);
      logic kind;
      logic [ELEMENT_W-1:0] elem;
      logic [LEVEL_W-1:0] lvl;
      int pick;
      for (int n = 0; n < items; n++) begin
         kind = ($urandom_range(0, 99) < push_pct) ? KIND_PUSH : KIND_POP;
         pick = $urandom_range(0, 9);
         elem = (pick == 0) ? '0 : (pick == 1) ? '1 : $urandom;
         if (highest_level < 4'd15 && $urandom_range(0, 4) == 0) begin
            lvl = LEVEL_W'($urandom_range(0, 15));
         end else begin
            lvl = LEVEL_W'($urandom_range(0, highest_level));
         end
         send_item(kind, elem, lvl, 1'b0, NO_CHECK);
      end
   endtask

   initial begin
      start <= 1'b0;
      req_kind <= KIND_PUSH;
      req_element <= '0;
      req_level <= '0;
      csr_write_enable <= 1'b0;
      csr_write_data <= '0;
      reset <= 1'b1;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      repeat (3) @(posedge clock);

      send_idle_pct = 27;
      foreach (directed_rows[i]) begin
         if (directed_rows[i].is_cfg) begin
            write_highest_level(directed_rows[i].level);
         end else begin
            send_item(directed_rows[i].kind, directed_rows[i].element, directed_rows[i].level,
                      directed_rows[i].checked, directed_rows[i].typed_res);
         end
      end

      write_highest_level(4'd15);
      run_random(420, 85);
      write_highest_level(4'd7);
      send_idle_pct = 81;
      run_random(420, 15);
      write_highest_level(4'd0);
      send_idle_pct = 0;
      run_random(120, 50);
      write_highest_level(4'd10);
      run_random(390, 50);

      start <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (mismatch_count == 0 && expected_q.size() == 0) begin
         $display("bucketed_priority_stack_top: match");
      end else begin
         $display("bucketed_priority_stack_top: mismatch");
      end
      $finish;
   end

endmodule

// File: files.f
design/bps_pkg.sv
design/bps_ctrl.sv
design/bps_datapath.sv
design/bucketed_priority_stack_top.sv
tb/bucketed_priority_stack_top_tb.sv
